// File: sv/upd_pkg.sv
// Shared types, character codes and hex helpers for the percent decoder.
// Used by every module of url_percent_decoder; depends on nothing.
package upd_pkg;

  // Character codes
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  // Default depth of the command queue between front and back
  localparam int QueueDepth = 2;

  // Most bytes one input character can release
  localparam int MaxBytes = 4;

  // Escape tracking: nothing held, '%' held, '%' plus one hex digit held
  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_t;

  // One decoded command: up to four bytes, the last one maybe a terminator
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     term;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Nibble value of a hex digit, either case
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h61) begin
      d = c - 8'h57;
    end else if (c >= 8'h41) begin
      d = c - 8'h37;
    end else begin
      d = c - 8'h30;
    end
    return d[3:0];
  endfunction

endpackage

// File: sv/url_percent_decoder.sv
// URL percent decoder: takes one encoded character per beat and gives decoded
// bytes; '%xx' becomes a byte, '+' a space, and a NUL or last-marked character
// ends the string with a NUL byte carrying out_last. A character is accepted
// every cycle while the output keeps up; a character releases at most 4 bytes
// (for a broken escape at the end of a string), and the output sends one byte
// per cycle while out_ready is high. A queue of QDEPTH commands lets input
// run on while the output drains; a byte passes through the queue and the
// back end's command register before it appears.
module url_percent_decoder #(
  parameter int QDEPTH = upd_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  upd_pkg::q_stat_t q_stat;
  upd_pkg::cmd_t    wr_cmd, rd_cmd;
  logic             push, pop;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_char  (in_char),
    .in_last  (in_last),
    .in_ready (in_ready),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (wr_cmd)
  );

  upd_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .q_stat (q_stat)
  );

  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_cmd    (rd_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // The terminator beat always carries a NUL byte
  a_term_is_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == upd_pkg::ChNul)
    else $error("terminator beat with nonzero byte");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full command queue");

  // With nothing queued and nothing shown, no byte can appear next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty && !out_valid |=> !out_valid)
    else $error("output beat without a queued command");

endmodule

// File: sv/upd_front.sv
// Front end of the percent decoder: accepts characters, tracks escape state
// and turns each accepted beat into at most one command of up to four bytes. Uses upd_pkg.
module upd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_char,
  input  logic            in_last,
  output logic            in_ready,
  input  upd_pkg::q_stat_t q_stat,
  output logic            push,
  output upd_pkg::cmd_t   cmd
);

  upd_pkg::phase_t phase, phase_next;
  logic [7:0]      held, held_next;
  logic            ended, ended_next;
  logic [2:0]      n;
  logic            c_hex;
  logic            accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (cmd.count != 3'd0);

  // Hold escape state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= upd_pkg::PhIdle;
      held  <= '0;
      ended <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
      ended <= ended_next;
    end
  end

  // Classify the character and build its byte list
  always_comb begin
    cmd        = '0;
    n          = '0;
    phase_next = phase;
    held_next  = held;
    ended_next = ended;
    c_hex      = upd_pkg::is_hex(in_char);
    if (ended) begin
      // Drop everything up to the last-marked beat
      if (in_last) begin
        ended_next = 1'b0;
        phase_next = upd_pkg::PhIdle;
        held_next  = '0;
      end
    end else if (in_char == upd_pkg::ChNul) begin
      // Flush held characters, then terminate
      if (phase == upd_pkg::PhPct || phase == upd_pkg::PhDigit) begin
        cmd.bytes[n[1:0]] = upd_pkg::ChPercent;
        n = n + 3'd1;
      end
      if (phase == upd_pkg::PhDigit) begin
        cmd.bytes[n[1:0]] = held;
        n = n + 3'd1;
      end
      cmd.bytes[n[1:0]] = upd_pkg::ChNul;
      n = n + 3'd1;
      cmd.term   = 1'b1;
      phase_next = upd_pkg::PhIdle;
      held_next  = '0;
      ended_next = !in_last;
    end else begin
      if (phase == upd_pkg::PhPct && c_hex) begin
        // First digit of an escape
        held_next  = in_char;
        phase_next = upd_pkg::PhDigit;
      end else if (phase == upd_pkg::PhDigit && c_hex) begin
        // Second digit: give the encoded byte
        cmd.bytes[n[1:0]] = {upd_pkg::hex_val(held), upd_pkg::hex_val(in_char)};
        n = n + 3'd1;
        phase_next = upd_pkg::PhIdle;
        held_next  = '0;
      end else begin
        // Plain character or broken escape: flush any held characters literally, then handle the character afresh
        if (phase == upd_pkg::PhPct || phase == upd_pkg::PhDigit) begin
          cmd.bytes[n[1:0]] = upd_pkg::ChPercent;
          n = n + 3'd1;
          held_next = '0;
        end
        if (phase == upd_pkg::PhDigit) begin
          cmd.bytes[n[1:0]] = held;
          n = n + 3'd1;
        end
        if (in_char == upd_pkg::ChPercent) begin
          phase_next = upd_pkg::PhPct;
        end else begin
          phase_next = upd_pkg::PhIdle;
          cmd.bytes[n[1:0]] = (in_char == upd_pkg::ChPlus) ? upd_pkg::ChSpace : in_char;
          n = n + 3'd1;
        end
      end
      // Last-marked character: flush what is still held and terminate
      if (in_last) begin
        if (phase_next == upd_pkg::PhPct || phase_next == upd_pkg::PhDigit) begin
          cmd.bytes[n[1:0]] = upd_pkg::ChPercent;
          n = n + 3'd1;
        end
        if (phase_next == upd_pkg::PhDigit) begin
          cmd.bytes[n[1:0]] = held_next;
          n = n + 3'd1;
        end
        cmd.bytes[n[1:0]] = upd_pkg::ChNul;
        n = n + 3'd1;
        cmd.term   = 1'b1;
        phase_next = upd_pkg::PhIdle;
        held_next  = '0;
      end
    end
    cmd.count = n;
  end

endmodule

// File: sv/upd_queue.sv
// Short command queue between the front and back of the percent decoder.
// Uses upd_pkg for the command and status types.
module upd_queue #(
  parameter int QDEPTH = upd_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  upd_pkg::cmd_t    wr_cmd,
  input  logic             pop,
  output upd_pkg::cmd_t    rd_cmd,
  output upd_pkg::q_stat_t q_stat
);

  localparam int PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CntW = $clog2(QDEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDEPTH);

  upd_pkg::cmd_t   slots [QDEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign q_stat.full  = (count == CntFull);
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_cmd       = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: sv/upd_back.sv
// Back end of the percent decoder: takes commands from the queue and sends
// their bytes one beat at a time. Uses upd_pkg for the command types.
module upd_back (
  input  logic             clk,
  input  logic             rst,
  input  upd_pkg::cmd_t    rd_cmd,
  input  upd_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  upd_pkg::cmd_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          at_end;
  logic          beat;

  assign at_end    = ({1'b0, idx} == cur.count - 3'd1);
  assign beat      = cur_valid && out_ready;
  assign pop       = !q_stat.empty && (!cur_valid || (out_ready && at_end));
  assign out_valid = cur_valid;
  assign out_byte  = cur.bytes[idx];
  assign out_last  = cur.term && at_end;

  // Load the next command or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (beat) begin
      if (at_end) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Hold the command payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_cmd;
    end
  end

endmodule

// File: sim/decoded_byte_checker.sv
// Byte checker for url_percent_decoder: watches both channels, predicts the decoded bytes
// of every accepted character and compares them with the output beats.
// Depends on upd_pkg for the character codes and the escape phase type.
module decoded_byte_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         due_count,
  output int         bytes_seen,
  output int         strings_seen
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } out_beat_t;

  // Decoded bytes still owed by the block, oldest first
  out_beat_t bytes_due[$];

  // Predicted escape state
  upd_pkg::phase_t esc_phase = upd_pkg::PhIdle;
  logic [7:0]      held_char = 8'h00;
  logic            string_done = 1'b0;
  int              errors = 0;

  // Return {is_digit, nibble} for one character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("[%0t] %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
  endtask

  task automatic owe_byte(input logic [7:0] value, input logic last);
    out_beat_t b;
    b.value = value;
    b.last  = last;
    bytes_due.push_back(b);
  endtask

  // Give back a pending '%' and held digit literally, then drop the escape
  task automatic release_held();
    case (esc_phase)
      upd_pkg::PhPct: begin
        owe_byte(upd_pkg::ChPercent, 1'b0);
      end
      upd_pkg::PhDigit: begin
        owe_byte(upd_pkg::ChPercent, 1'b0);
        owe_byte(held_char, 1'b0);
      end
      default: ;
    endcase
    esc_phase = upd_pkg::PhIdle;
    held_char = 8'h00;
  endtask

  // Character seen with no escape pending
  task automatic take_plain(input logic [7:0] c);
    if (c == upd_pkg::ChPercent) begin
      esc_phase = upd_pkg::PhPct;
    end else begin
      esc_phase = upd_pkg::PhIdle;
      owe_byte((c == upd_pkg::ChPlus) ? upd_pkg::ChSpace : c, 1'b0);
    end
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [4:0] hi;
    logic [4:0] lo;
    lo = hex_digit(c);
    if (string_done) begin
      // Drop everything up to and including the next last-marked beat
      if (last) begin
        string_done = 1'b0;
        esc_phase   = upd_pkg::PhIdle;
        held_char   = 8'h00;
      end
    end else if (c == upd_pkg::ChNul) begin
      release_held();
      owe_byte(upd_pkg::ChNul, 1'b1);
      string_done = !last;
    end else begin
      case (esc_phase)
        upd_pkg::PhPct: begin
          if (lo[4]) begin
            held_char = c;
            esc_phase = upd_pkg::PhDigit;
          end else begin
            release_held();
            take_plain(c);
          end
        end
        upd_pkg::PhDigit: begin
          if (lo[4]) begin
            hi = hex_digit(held_char);
            owe_byte({hi[3:0], lo[3:0]}, 1'b0);
            esc_phase = upd_pkg::PhIdle;
            held_char = 8'h00;
          end else begin
            release_held();
            take_plain(c);
          end
        end
        default: take_plain(c);
      endcase
      // A last-marked character closes the string after its own bytes
      if (last) begin
        release_held();
        owe_byte(upd_pkg::ChNul, 1'b1);
      end
    end
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin : watch_beats
    out_beat_t want;
    if (rst) begin
      esc_phase   = upd_pkg::PhIdle;
      held_char   = 8'h00;
      string_done = 1'b0;
      bytes_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_char(in_char, in_last);
      end
      if (out_valid && out_ready) begin
        bytes_seen <= bytes_seen + 1;
        if (out_last) begin
          strings_seen <= strings_seen + 1;
        end
        if (bytes_due.size() == 0) begin
          report_mismatch("unexpected output beat", out_byte, 8'h00);
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.value) begin
            report_mismatch("out_byte mismatch", out_byte, want.value);
          end
          if (out_last !== want.last) begin
            report_mismatch("out_last mismatch", {7'b0, out_last}, {7'b0, want.last});
          end
        end
      end
    end
    fail_count <= errors;
    due_count  <= bytes_due.size();
  end

endmodule

// File: sim/url_percent_decoder_tb.sv
// Testbench top for url_percent_decoder: drives encoded strings with random idling,
// a long output stall and a drain pause, and reports the verdict.
// Depends on upd_pkg, url_percent_decoder and decoded_byte_checker.
module url_percent_decoder_tb;

  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 150;
  localparam int RandomItems = 120;
  localparam int CalmItems   = 30;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  logic hold_long = 1'b0;
  logic calm = 1'b0;
  int   body_items = 0;
  int   chars_sent = 0;

  int fail_count;
  int due_count;
  int bytes_seen;
  int strings_seen;

  url_percent_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  decoded_byte_checker byte_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .due_count    (due_count),
    .bytes_seen   (bytes_seen),
    .strings_seen (strings_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one character beat, maybe after an idle burst, and wait for it to go in
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_str(input string s, input logic mark_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], mark_last && (i == s.len() - 1));
    end
  endtask

  // Stop offering and hold until every owed byte has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Hex digit character for a nibble, random case for letters
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + n;
    end
    return ($urandom_range(0, 1) != 0) ? 8'h57 + n : 8'h37 + n;
  endfunction

  // Build one string of plain text, escapes and noise, then end it one of three ways
  task automatic send_random_string();
    logic [7:0] text[$];
    logic [7:0] ch;
    int         len;
    int         kind;
    int         ending;
    int         tail;
    len = $urandom_range(1, 10);
    repeat (len) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        ch = 8'($urandom_range(8'h21, 8'h7E));
        text.push_back(ch);
      end else if (kind < 50) begin
        text.push_back(upd_pkg::ChPlus);
      end else if (kind < 75) begin
        text.push_back(upd_pkg::ChPercent);
        text.push_back(hex_char(4'($urandom_range(0, 15))));
        text.push_back(hex_char(4'($urandom_range(0, 15))));
      end else if (kind < 85) begin
        // broken escape, cut after the '%' or after one digit
        text.push_back(upd_pkg::ChPercent);
        if ($urandom_range(0, 1) != 0) begin
          text.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        ch = 8'($urandom_range(8'h67, 8'h7A));
        text.push_back(ch);
      end else begin
        ch = 8'($urandom_range(1, 255));
        text.push_back(ch);
      end
    end
    ending = $urandom_range(0, 3);
    if (ending >= 2) begin
      text.push_back(upd_pkg::ChNul);
    end
    body_items += text.size();
    foreach (text[i]) begin
      send_char(text[i], (ending != 3) && (i == text.size() - 1));
    end
    // NUL without last: trailing beats are dropped up to the last-marked one
    if (ending == 3) begin
      tail = $urandom_range(0, 3);
      repeat (tail) begin
        ch = 8'($urandom_range(0, 255));
        send_char(ch, 1'b0);
      end
      ch = 8'($urandom_range(0, 255));
      send_char(ch, 1'b1);
    end
  endtask

  // Output side: random stall bursts, one long hold-off on request
  initial begin : drain_side
    wait (rst == 1'b0);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_long <= 1'b0;
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // End the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no beat moved for %0d cycles", StallLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Escapes in both cases, extreme byte values, '+' and raw extremes
    send_str("%41%fF%00+", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h01, 1'b0);
    // Double '%' then a digit and a non-hex character
    send_str("%%4g", 1'b0);
    // Last-marked '%' after a held digit: four bytes from one beat
    send_str("%A%", 1'b1);
    // NUL without last, then dropped beats up to the last-marked one
    send_char(upd_pkg::ChNul, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(8'h79, 1'b1);
    // End inside an escape on a last-marked NUL
    send_char(upd_pkg::ChPercent, 1'b0);
    send_char(upd_pkg::ChNul, 1'b1);

    // Long output stall while characters keep coming, then a full drain
    hold_long <= 1'b1;
    send_str("a+b%7E%zz%41cd%4", 1'b1);
    wait_drained();

    while (body_items < RandomItems) begin
      if (body_items >= RandomItems - CalmItems) begin
        calm <= 1'b1;
      end
      send_random_string();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d characters; checked %0d decoded bytes over %0d strings,",
             chars_sent, bytes_seen, strings_seen);
    $display("including broken escapes, dropped tails and a %0d-cycle output stall.",
             HoldCycles);
    if (fail_count == 0 && due_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_queue.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
sim/decoded_byte_checker.sv
sim/url_percent_decoder_tb.sv
